### rtl/core/assert_macros.svh
// Assertion macros shared by the key scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define KSL_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("key scanner assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KSL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("key scanner assertion failed");

`endif

### rtl/core/ksl_pkg.sv
// Shared types, constants and codes of the key scanner.
`timescale 1ns / 1ps
package ksl_pkg;
	localparam int DEF_NUM_KEYS   = 4;
	localparam int DEF_FIFO_DEPTH = 16;

	localparam int CODE_W  = 4;
	localparam int COUNT_W = 8;
	localparam int CFG_W   = 8;
	localparam int FUNC_W  = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [CFG_W-1:0] FILTER_RESET = 8'd2;
	localparam logic [CFG_W-1:0] LONG_RESET   = 8'd10;

	localparam int SHORT_BASE = 1;
	localparam int LONG_BASE  = 5;

	localparam logic [FUNC_W-1:0] FUNC_SCAN  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG   = 1'd1;

	// One key lane's request to queue a code in this scan tick.
	typedef struct packed {
		logic              push;
		logic [CODE_W-1:0] code;
	} lane_evt_t;
endpackage

### rtl/core/ksl_lane.sv
// One key lane: press counter and short or long press decision.
`timescale 1ns / 1ps
module ksl_lane #(
	parameter int KEY_IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        scan_en,
	input  logic                        level,
	input  logic [ksl_pkg::CFG_W-1:0]   filter_ticks,
	input  logic [ksl_pkg::CFG_W-1:0]   long_ticks,
	output ksl_pkg::lane_evt_t          evt,
	output logic                        held
);
	import ksl_pkg::*;

	localparam logic [CODE_W-1:0] SHORT_CODE = CODE_W'(KEY_IDX + SHORT_BASE);
	localparam logic [CODE_W-1:0] LONG_CODE  = CODE_W'(KEY_IDX + LONG_BASE);

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_inc;
	logic [COUNT_W-1:0] count_d;
	logic               held_q;

	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);

	always_comb begin
		evt.push = 1'b0;
		evt.code = LONG_CODE;
		count_d  = count_q;
		if (scan_en) begin
			if (!level) begin
				// Pressed: count up, and fire a repeating long event at the limit.
				count_d = count_inc;
				if (count_inc >= long_ticks) begin
					evt.push = 1'b1;
					count_d  = '0;
				end
			end else begin
				// Released: classify what was held, then restart.
				if (count_q >= filter_ticks) begin
					evt.push = 1'b1;
					evt.code = (count_q < long_ticks) ? SHORT_CODE : LONG_CODE;
				end
				count_d = '0;
			end
		end
	end

	assign held = scan_en ? !level : held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			held_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			held_q  <= held;
		end
	end
endmodule

### rtl/core/ksl_merge.sv
// Merge stage: queues lane events in key order into the code ring and serves pops.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ksl_merge #(
	parameter int NUM_KEYS   = ksl_pkg::DEF_NUM_KEYS,
	parameter int FIFO_DEPTH = ksl_pkg::DEF_FIFO_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ksl_pkg::lane_evt_t [NUM_KEYS-1:0] events,
	input  logic                              pop_en,
	input  logic                              clear_en,
	output logic [ksl_pkg::CODE_W-1:0]        pop_code
);
	import ksl_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);

	logic [CODE_W-1:0] store_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_d;
	logic [PTR_W-1:0]  rd_ptr_d;
	logic [PTR_W-1:0]  slot [NUM_KEYS];
	logic              empty;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
	endfunction

	// Each pushing lane takes the next slot after the lanes below it.
	always_comb begin
		wr_ptr_d = wr_ptr_q;
		for (int j = 0; j < NUM_KEYS; j++) begin
			slot[j] = wr_ptr_d;
			if (events[j].push) begin
				wr_ptr_d = next_slot(wr_ptr_d);
			end
		end
	end

	assign empty    = (rd_ptr_q == wr_ptr_q);
	assign pop_code = empty ? '0 : store_q[rd_ptr_q];

	always_comb begin
		rd_ptr_d = rd_ptr_q;
		if (clear_en) begin
			rd_ptr_d = wr_ptr_q;
		end else if (pop_en && !empty) begin
			rd_ptr_d = next_slot(rd_ptr_q);
		end
	end

	// With no full check a small ring may be lapped within one tick;
	// the higher key is written last and wins.
	always_ff @(posedge clk) begin
		for (int e = 0; e < FIFO_DEPTH; e++) begin
			for (int j = 0; j < NUM_KEYS; j++) begin
				if (events[j].push && slot[j] == PTR_W'(e)) begin
					store_q[e] <= events[j].code;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_d;
			wr_ptr_q <= wr_ptr_d;
		end
	end

	`KSL_ASSERT_ALWAYS(a_rd_ptr_range, rd_ptr_q <= LAST_SLOT)
	`KSL_ASSERT_ALWAYS(a_wr_ptr_range, wr_ptr_q <= LAST_SLOT)
	`KSL_ASSERT_NEXT(a_clear_empties, clear_en, rd_ptr_q == wr_ptr_q)
endmodule

### rtl/core/ksl_obuf.sv
// Two-entry result buffer between the core and the output channel.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ksl_obuf #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             can_push,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	logic [WIDTH-1:0] head_q;
	logic [WIDTH-1:0] tail_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign can_push  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = head_q;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				tail_q <= push_data;
			end
		end else if (pop && !push) begin
			head_q <= tail_q;
		end else if (push && pop) begin
			if (cnt_q == 2'd1) begin
				head_q <= push_data;
			end else begin
				head_q <= tail_q;
				tail_q <= push_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	`KSL_ASSERT_ALWAYS(a_cnt_range, cnt_q <= 2'd2)
	`KSL_ASSERT_NEXT(a_push_grows, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
endmodule

### rtl/core/key_scan_long_press_fifo.sv
// Top level of the key scanner with short and long press events and a code ring.
`timescale 1ns / 1ps
// Key scanner with press classification and an event code ring. Every input
// transfer is one command: a scan tick (func 0) samples one active-low level
// per key, a pop (func 1) takes the oldest queued code (0 when the ring is
// empty), and a clear (func 2) drops everything queued; func 3 does nothing.
// Each command yields exactly one output transfer carrying the popped code
// (0 for anything but a successful pop) and the mask of keys held after the
// command. One lane per key counts held ticks and decides short or long
// events; a merge stage writes the events of one tick into the ring in key
// order, up to NUM_KEYS codes per tick, with no overflow check, so a full
// ring wraps and overwrites old codes. The block takes one command per clock
// unless stalled: all state updates in the cycle of the input transfer and
// the result is registered in a two-entry output buffer that sets the stall
// behavior: input ready drops only when two results wait untaken. The ring
// is held in flip-flops and needs no clearing after reset. Registers
// filter_ticks (index 0, reset 2) and long_ticks (index 1, reset 10) are
// written through cfg_we by the user only while idle, unchecked by the block.
module key_scan_long_press_fifo #(
	parameter int NUM_KEYS   = ksl_pkg::DEF_NUM_KEYS,
	parameter int FIFO_DEPTH = ksl_pkg::DEF_FIFO_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ksl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ksl_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ksl_pkg::FUNC_W-1:0]     func,
	input  logic [NUM_KEYS-1:0]            key_levels,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ksl_pkg::CODE_W-1:0]     key_code,
	output logic [NUM_KEYS-1:0]            held_mask
);
	import ksl_pkg::*;

	localparam int RES_W = CODE_W + NUM_KEYS;

	logic [CFG_W-1:0]               filter_q;
	logic [CFG_W-1:0]               long_q;
	logic                           accept;
	logic                           scan_en;
	logic                           pop_en;
	logic                           clear_en;
	lane_evt_t [NUM_KEYS-1:0]       events;
	logic [NUM_KEYS-1:0]            held_now;
	logic [CODE_W-1:0]              pop_code;
	logic [RES_W-1:0]               result;
	logic [RES_W-1:0]               out_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= FILTER_RESET;
			long_q   <= LONG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FILTER: filter_q <= cfg_wdata;
				REG_LONG:   long_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign accept = in_valid && in_ready;

	// Command decode; only an accepted transfer touches state.
	always_comb begin
		scan_en  = 1'b0;
		pop_en   = 1'b0;
		clear_en = 1'b0;
		unique case (func)
			FUNC_SCAN:  scan_en  = accept;
			FUNC_POP:   pop_en   = accept;
			FUNC_CLEAR: clear_en = accept;
			default: ;
		endcase
	end

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		ksl_lane #(
			.KEY_IDX(k)
		) u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.scan_en      (scan_en),
			.level        (key_levels[k]),
			.filter_ticks (filter_q),
			.long_ticks   (long_q),
			.evt          (events[k]),
			.held         (held_now[k])
		);
	end

	ksl_merge #(
		.NUM_KEYS   (NUM_KEYS),
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.events   (events),
		.pop_en   (pop_en),
		.clear_en (clear_en),
		.pop_code (pop_code)
	);

	// A pop that finds the ring empty already gives zero; other commands give zero too.
	assign result = {(pop_en ? pop_code : CODE_W'(0)), held_now};

	ksl_obuf #(
		.WIDTH(RES_W)
	) u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign key_code  = out_data[RES_W-1:NUM_KEYS];
	assign held_mask = out_data[NUM_KEYS-1:0];
endmodule
